// ===== hdl/ldbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbc_pkg: shared types and helpers for the Lucas divisibility count unit
// Holds the sequencer state type, the divider status bundle and the
// single-bit restoring division step used by the digit splitter.
// ----------------------------------------------------------------------------
package ldbc_pkg;

    localparam int DIGIT_W = 16;
    localparam int FIELD_W = 64;

    localparam logic [DIGIT_W-1:0] RADIX_RESET = 16'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MIN   = 16'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIGIT,
        ST_RD,
        ST_MUL,
        ST_ADD,
        ST_FINISH
    } ldbc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] rem;
        logic               qbit;
    } div_step_t;

    // One restoring division step: shift the next dividend bit into the
    // partial remainder and subtract the divisor if it fits.
    function automatic div_step_t div_step(
        input logic [DIGIT_W-1:0] rem,
        input logic               in_bit,
        input logic [DIGIT_W-1:0] divisor
    );
        logic [DIGIT_W:0] part;
        logic [DIGIT_W:0] diff;
        div_step_t        res;
        part = {rem, in_bit};
        diff = part - {1'b0, divisor};
        if (part >= {1'b0, divisor})
        begin
            res.rem  = diff[DIGIT_W-1:0];
            res.qbit = 1'b1;
        end
        else
        begin
            res.rem  = part[DIGIT_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

// ===== hdl/ldbc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbc_divider: two-lane bit-serial divider by the radix
// Divides two operands by the same divisor, one quotient bit per cycle,
// giving both quotients and remainders once the last dividend bit is shifted in.
// ----------------------------------------------------------------------------
module ldbc_divider
    import ldbc_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIGIT_W-1:0]   divisor,
    input  logic [WORD_BITS-1:0] dividend_a,
    input  logic [WORD_BITS-1:0] dividend_b,
    output div_stat_t            stat,
    output logic [WORD_BITS-1:0] quotient_a,
    output logic [WORD_BITS-1:0] quotient_b,
    output logic [DIGIT_W-1:0]   remainder_a,
    output logic [DIGIT_W-1:0]   remainder_b
);

    localparam int STEP_W = $clog2(WORD_BITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_BITS - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [WORD_BITS-1:0] quo_a_reg, quo_a_next;
    logic [WORD_BITS-1:0] quo_b_reg, quo_b_next;
    logic [DIGIT_W-1:0]   rem_a_reg, rem_a_next;
    logic [DIGIT_W-1:0]   rem_b_reg, rem_b_next;
    div_step_t            lane_a, lane_b;

    assign lane_a = div_step(rem_a_reg, quo_a_reg[WORD_BITS-1], divisor);
    assign lane_b = div_step(rem_b_reg, quo_b_reg[WORD_BITS-1], divisor);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        quo_a_next = quo_a_reg;
        quo_b_next = quo_b_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            quo_a_next = dividend_a;
            quo_b_next = dividend_b;
            rem_a_next = '0;
            rem_b_next = '0;
        end
        else if (busy_reg)
        begin
            // The dividend register shifts out its top bit and takes the new
            // quotient bit at the bottom.
            quo_a_next = {quo_a_reg[WORD_BITS-2:0], lane_a.qbit};
            quo_b_next = {quo_b_reg[WORD_BITS-2:0], lane_b.qbit};
            rem_a_next = lane_a.rem;
            rem_b_next = lane_b.rem;
            step_next  = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_a_reg <= quo_a_next;
        quo_b_reg <= quo_b_next;
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
    end

    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;
    assign quotient_a  = quo_a_reg;
    assign quotient_b  = quo_b_reg;
    assign remainder_a = rem_a_reg;
    assign remainder_b = rem_b_reg;

endmodule

// ===== hdl/lucas_divisible_binomial_count_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lucas_divisible_binomial_count_unit: Lucas-theorem divisibility counter
// Counts the x below n whose base-p digits are dominated by those of m
// (miss_count) and the rest (hit_count), by a digit walk over stored digits.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  cfg       cfg_valid / cfg_ready   radix
//  in        in_valid  / in_ready    upper_param, limit
//  out       out_valid / out_ready   hit_count, miss_count
//
// A request runs the divider once per base-p digit of the longer of n-1 and m,
// then walks the stored digits from the top, at most as many as were split.
// The bit-serial divider takes the bulk of the time of a request.
// A new request is taken only in the idle state; a finished result waits in
// the output register and does not block the next request from entering.
// Reset sets the radix to two and empties the pipeline; cfg_ready is always high.
// ----------------------------------------------------------------------------
module lucas_divisible_binomial_count_unit
    import ldbc_pkg::*;
#(
    parameter int MAX_DIGITS = 64,
    parameter int WORD_BITS  = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DIGIT_W-1:0] radix,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FIELD_W-1:0] upper_param,
    input  logic [FIELD_W-1:0] limit,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] hit_count,
    output logic [FIELD_W-1:0] miss_count
);

    localparam int IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int ENTRY_W = 2 * DIGIT_W + WORD_BITS;
    localparam int PROD_W  = WORD_BITS + DIGIT_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_DIGITS - 1);

    ldbc_state_t          state_reg, state_next;
    logic [DIGIT_W-1:0]   radix_reg;
    logic [DIGIT_W-1:0]   radix_eff;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [WORD_BITS-1:0] n_reg, n_next;
    logic [WORD_BITS-1:0] wt_reg, wt_next;
    logic [WORD_BITS-1:0] total_reg, total_next;
    logic [WORD_BITS-1:0] prod_reg, prod_next;
    logic                 stop_reg, stop_next;
    logic [WORD_BITS-1:0] hit_reg, hit_next;
    logic [WORD_BITS-1:0] miss_reg, miss_next;
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic [ENTRY_W-1:0]   dig_mem [MAX_DIGITS];

    logic [WORD_BITS-1:0] m_in, n_in;
    logic                 in_fire;
    logic                 mem_we;
    logic [ENTRY_W-1:0]   mem_wdata;

    logic                 div_start;
    logic [WORD_BITS-1:0] div_a, div_b;
    div_stat_t            div_stat;
    logic [WORD_BITS-1:0] quo_a, quo_b;
    logic [DIGIT_W-1:0]   rem_a, rem_b;

    logic [DIGIT_W-1:0]   rd_ydig, rd_mdig;
    logic [WORD_BITS-1:0] rd_wt;
    logic [DIGIT_W-1:0]   choices;
    logic [WORD_BITS-1:0] mul_a;
    logic [DIGIT_W-1:0]   mul_b;
    logic [PROD_W-1:0]    mul_full;
    logic [WORD_BITS-1:0] mul_res;
    logic [WORD_BITS-1:0] acc_sum;

    assign m_in      = upper_param[WORD_BITS-1:0];
    assign n_in      = limit[WORD_BITS-1:0];
    assign in_fire   = in_valid && in_ready;
    assign radix_eff = (radix_reg < RADIX_MIN) ? RADIX_MIN : radix_reg;
    assign cfg_ready = 1'b1;

    assign rd_ydig = rd_data_reg[ENTRY_W-1 -: DIGIT_W];
    assign rd_mdig = rd_data_reg[ENTRY_W-DIGIT_W-1 -: DIGIT_W];
    assign rd_wt   = rd_data_reg[WORD_BITS-1:0];
    assign choices = (rd_ydig <= rd_mdig) ? rd_ydig : rd_mdig + DIGIT_W'(1);

    // The one multiplier builds the weights while splitting and the partial
    // counts while walking.
    always_comb
    begin
        if (state_reg == ST_DIGIT)
        begin
            mul_a = wt_reg;
            mul_b = rem_b + DIGIT_W'(1);
        end
        else
        begin
            mul_a = rd_wt;
            mul_b = choices;
        end
    end

    assign mul_full = {{DIGIT_W{1'b0}}, mul_a} * {{WORD_BITS{1'b0}}, mul_b};
    assign mul_res  = mul_full[WORD_BITS-1:0];
    assign acc_sum  = total_reg + prod_reg;

    assign mem_wdata = {rem_a, rem_b, wt_reg};

    ldbc_divider #(
        .WORD_BITS(WORD_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .divisor    (radix_eff),
        .dividend_a (div_a),
        .dividend_b (div_b),
        .stat       (div_stat),
        .quotient_a (quo_a),
        .quotient_b (quo_b),
        .remainder_a(rem_a),
        .remainder_b(rem_b)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        wt_next        = wt_reg;
        total_next     = total_reg;
        prod_next      = prod_reg;
        stop_next      = stop_reg;
        hit_next       = hit_reg;
        miss_next      = miss_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        mem_we         = 1'b0;
        div_start      = 1'b0;
        div_a          = quo_a;
        div_b          = quo_b;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                div_a    = n_in - WORD_BITS'(1);
                div_b    = m_in;
                if (in_fire)
                begin
                    n_next    = n_in;
                    idx_next  = '0;
                    wt_next   = WORD_BITS'(1);
                    total_next = '0;
                    if (n_in == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                mem_we  = 1'b1;
                wt_next = mul_res;
                // Keep splitting while either operand still has digits left and the digit store has room.
                if (((quo_a != '0) || (quo_b != '0)) && (idx_reg != IDX_LAST))
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    total_next = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = mul_res;
                stop_next  = rd_ydig > rd_mdig;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (stop_reg)
                begin
                    total_next = acc_sum;
                    state_next = ST_FINISH;
                end
                else if (idx_reg == '0)
                begin
                    // Every digit of n-1 fit under m, so n-1 itself counts.
                    total_next = acc_sum + WORD_BITS'(1);
                    state_next = ST_FINISH;
                end
                else
                begin
                    total_next = acc_sum;
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    hit_next       = n_reg - total_reg;
                    miss_next      = total_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            radix_reg     <= RADIX_RESET;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            if (cfg_valid && cfg_ready)
            begin
                radix_reg <= radix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        wt_reg    <= wt_next;
        total_reg <= total_next;
        prod_reg  <= prod_next;
        stop_reg  <= stop_next;
        hit_reg   <= hit_next;
        miss_reg  <= miss_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dig_mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= dig_mem[idx_reg];
    end

    assign out_valid  = out_valid_reg;
    assign hit_count  = FIELD_W'(hit_reg);
    assign miss_count = FIELD_W'(miss_reg);

endmodule

// ===== hdl/ldbc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldbc_checker: port-level checks for the Lucas divisibility count unit
// Tracks requests in flight from the handshakes and checks that results
// are neither invented nor overrun, bound to every instance of the top level.
// ----------------------------------------------------------------------------
module ldbc_checker
    import ldbc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [FIELD_W-1:0] hit_count,
    input logic [FIELD_W-1:0] miss_count
);

    logic [1:0] pend_reg, pend_next;
    logic       in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_fire && !out_fire)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_fire && out_fire)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_count) && $stable(miss_count))
        else $error("result changed while stalled");

    // The unit works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("request accepted while a request is being worked on");

    // No result appears without a request behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without a pending request");

    // With one result waiting and one request at work, no third may enter.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !in_ready)
        else $error("more than two requests in flight");

endmodule

bind lucas_divisible_binomial_count_unit ldbc_checker u_ldbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit_count (hit_count),
    .miss_count(miss_count)
);
